### hdl/http_response_dechunker_defines.svh
`ifndef HTTP_RESPONSE_DECHUNKER_DEFINES_SVH
`define HTTP_RESPONSE_DECHUNKER_DEFINES_SVH

// Check a property on the rising clock edge, off while reset is held
`define HRDC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hrdc check failed");

// Check that a stalled word holds its valid and payload
`define HRDC_ASSERT_HOLD(lbl, clk, rst_n, vld, rdy, data) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(data))) \
        else $error("hrdc stalled word changed");

`endif

### hdl/hrdc_pkg.sv
`default_nettype none

package hrdc_pkg;

    localparam int CHUNK_SIZE_BITS_DEF = 32;

    localparam int WIN_LEN  = 26;
    localparam int WIN_BITS = WIN_LEN * 8;

    localparam logic [63:0]         TAG11        = "HTTP/1.1";
    localparam logic [63:0]         TAG10        = "HTTP/1.0";
    localparam logic [WIN_BITS-1:0] CHUNK_PHRASE = "Transfer-Encoding: chunked";
    localparam logic [31:0]         END_MARK     = 32'h0D0A_0D0A;
    localparam logic [15:0]         CRLF         = 16'h0D0A;
    localparam logic [7:0]          CHAR_CR      = 8'h0D;
    localparam logic [7:0]          CHAR_LF      = 8'h0A;

    localparam logic [13:0] STATUS_MAX = 14'd9999;

    localparam logic [1:0] KIND_BODY    = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    localparam logic [1:0] VER_10   = 2'd0;
    localparam logic [1:0] VER_11   = 2'd1;
    localparam logic [1:0] VER_NONE = 2'd2;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_STATUS = 3'd1;
    localparam logic [2:0] PH_PLAIN  = 3'd2;
    localparam logic [2:0] PH_SIZE   = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_SKIP   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  body;
        logic [13:0] status;
        logic [1:0]  ver;
        logic        chk;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    e0;
        t_result    e1;
    } t_push;

    // bit 4 set when the byte is a hex digit, low nibble its value
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= "0" && b <= "9") begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= "a" && b <= "f") begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= "A" && b <= "F") begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/http_response_dechunker.sv
// HTTP response dechunker: takes the raw response one byte per word and, when the
// header's blank line arrives, emits one summary word (status code, version,
// chunked flag), then the body bytes, undone from chunked encoding where the
// header announced it. A byte marked last adds an end word, preceded by a summary
// when the header never finished, and returns the block to its reset state. One
// byte is taken every cycle while the queue has room; each byte is worked
// combinationally against the 26-byte header window and the size counters, and
// its results, if any, enter a four-entry result queue that registers them and
// presents the oldest. The input stalls only when fewer than two queue entries
// are free, so with the output always ready the rate is one byte per cycle; a run
// of bytes that each give two results, such as back-to-back bytes marked last,
// outruns the one-word-per-cycle output, which then stalls the input.
`default_nettype none

module http_response_dechunker
    import hrdc_pkg::*;
#(
    parameter int CHUNK_SIZE_BITS = CHUNK_SIZE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] stream_byte
    input  wire logic        i_s_tlast,   // end_of_stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,   // [7:0] body_byte, [21:8] status_code,
                                          // [23:22] http_version, [24] is_chunked
    output logic [1:0]       o_m_tuser,   // [1:0] result_kind
    output logic             o_m_tlast    // run_last
);

    localparam int W = CHUNK_SIZE_BITS;

    logic [2:0]          r_phase,    n_phase;
    logic [WIN_BITS-1:0] r_win,      n_win;
    logic [13:0]         r_status,   n_status;
    logic [1:0]          r_ver,      n_ver;
    logic                r_chk,      n_chk;
    logic [W-1:0]        r_size,     n_size;
    logic                r_closed,   n_closed;
    logic [1:0]          r_line_len, n_line_len;
    logic [W-1:0]        r_remain,   n_remain;
    logic [1:0]          r_skip,     n_skip;

    logic                w_acc;
    logic [7:0]          w_b;
    logic [WIN_BITS-1:0] w_push;
    logic [17:0]         w_stat10;
    logic [4:0]          w_hex;
    logic                w_prev_cr;
    logic                w_pa;
    logic                w_pe;
    t_result             w_ra;
    t_result             w_rsum;
    t_result             w_rend;
    t_push               w_push_q;
    t_result             w_head;
    logic                w_room;

    assign w_b       = i_s_tdata;
    assign w_acc     = i_s_tvalid && o_s_tready;
    assign o_s_tready = w_room && i_rst_n;
    assign w_push    = {r_win[WIN_BITS-9:0], w_b};
    assign w_stat10  = {1'b0, r_status, 3'b000} + {3'b000, r_status, 1'b0}
                     + {14'd0, 4'(w_b - 8'h30)};
    assign w_hex     = hex_decode(w_b);
    assign w_prev_cr = (r_line_len != 2'd0) && (r_win[7:0] == CHAR_CR);

    always_comb begin
        n_phase    = r_phase;
        n_win      = r_win;
        n_status   = r_status;
        n_ver      = r_ver;
        n_chk      = r_chk;
        n_size     = r_size;
        n_closed   = r_closed;
        n_line_len = r_line_len;
        n_remain   = r_remain;
        n_skip     = r_skip;
        w_pa       = 1'b0;
        w_ra       = '0;

        unique case (r_phase)
            PH_HEADER: begin
                n_win = w_push;
                priority if (r_ver == VER_NONE && w_push[63:0] == TAG11) begin
                    n_ver    = VER_11;
                    n_status = '0;
                    n_phase  = PH_STATUS;
                end else if (r_ver == VER_NONE && w_push[63:0] == TAG10) begin
                    n_ver    = VER_10;
                    n_status = '0;
                    n_phase  = PH_STATUS;
                end else if (!r_chk && w_push == CHUNK_PHRASE) begin
                    n_chk = 1'b1;
                end else if (w_push[31:0] == END_MARK) begin
                    w_pa        = 1'b1;
                    w_ra.kind   = KIND_SUMMARY;
                    w_ra.status = r_status;
                    w_ra.ver    = r_ver;
                    w_ra.chk    = r_chk;
                    if (r_chk) begin
                        n_phase    = PH_SIZE;
                        n_size     = '0;
                        n_closed   = 1'b0;
                        n_line_len = 2'd0;
                    end else begin
                        n_phase = PH_PLAIN;
                    end
                end
            end
            PH_STATUS: begin
                n_win = w_push;
                priority if (w_b >= "0" && w_b <= "9") begin
                    n_status = (w_stat10 > {4'd0, STATUS_MAX}) ? STATUS_MAX
                                                               : w_stat10[13:0];
                end else if (w_push[15:0] == CRLF) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_PLAIN: begin
                w_pa      = 1'b1;
                w_ra.kind = KIND_BODY;
                w_ra.body = w_b;
            end
            PH_SIZE: begin
                if (w_b == CHAR_LF && w_prev_cr) begin
                    if (r_line_len >= 2'd2) begin
                        n_remain = r_size;
                        if (r_size == '0) begin
                            n_skip  = 2'd2;
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end else begin
                        n_phase = PH_DONE;
                    end
                    n_size     = '0;
                    n_closed   = 1'b0;
                    n_line_len = 2'd0;
                end else begin
                    if (!r_closed) begin
                        if (!w_hex[4]) begin
                            n_closed = 1'b1;
                        end else if (r_size[W-1 -: 4] != 4'd0) begin
                            n_size = '1;
                        end else begin
                            n_size = {r_size[W-5:0], w_hex[3:0]};
                        end
                    end
                    n_win = w_push;
                    if (r_line_len != 2'd3) begin
                        n_line_len = r_line_len + 2'd1;
                    end
                end
            end
            PH_DATA: begin
                w_pa      = 1'b1;
                w_ra.kind = KIND_BODY;
                w_ra.body = w_b;
                if (r_remain != '0) begin
                    n_remain = r_remain - W'(1);
                end
                if (r_remain <= W'(1)) begin
                    n_skip  = 2'd2;
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (r_skip != 2'd0) begin
                    n_skip = r_skip - 2'd1;
                end
                if (r_skip <= 2'd1) begin
                    n_phase = PH_SIZE;
                end
            end
            default: begin
            end
        endcase

        w_pe          = i_s_tlast && (n_phase == PH_HEADER || n_phase == PH_STATUS);
        w_rsum        = '0;
        w_rsum.kind   = KIND_SUMMARY;
        w_rsum.status = n_status;
        w_rsum.ver    = n_ver;
        w_rsum.chk    = n_chk;
        w_rend        = '0;
        w_rend.kind   = KIND_END;
        w_rend.last   = 1'b1;

        // order: phase result, late summary, end word
        w_push_q = '0;
        if (w_pa) begin
            w_push_q.e0 = w_ra;
            if (i_s_tlast) begin
                w_push_q.e1 = w_pe ? w_rsum : w_rend;
                w_push_q.cnt = 2'd2;
            end else begin
                w_push_q.e0.last = 1'b1;
                w_push_q.cnt     = 2'd1;
            end
        end else if (w_pe) begin
            w_push_q.e0  = w_rsum;
            w_push_q.e1  = w_rend;
            w_push_q.cnt = 2'd2;
        end else if (i_s_tlast) begin
            w_push_q.e0  = w_rend;
            w_push_q.cnt = 2'd1;
        end
        if (!w_acc) begin
            w_push_q.cnt = 2'd0;
        end

        if (i_s_tlast) begin
            n_phase    = PH_HEADER;
            n_win      = '0;
            n_status   = '0;
            n_ver      = VER_NONE;
            n_chk      = 1'b0;
            n_size     = '0;
            n_closed   = 1'b0;
            n_line_len = 2'd0;
            n_remain   = '0;
            n_skip     = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_win      <= '0;
            r_status   <= '0;
            r_ver      <= VER_NONE;
            r_chk      <= 1'b0;
            r_size     <= '0;
            r_closed   <= 1'b0;
            r_line_len <= 2'd0;
            r_remain   <= '0;
            r_skip     <= 2'd0;
        end else if (w_acc) begin
            r_phase    <= n_phase;
            r_win      <= n_win;
            r_status   <= n_status;
            r_ver      <= n_ver;
            r_chk      <= n_chk;
            r_size     <= n_size;
            r_closed   <= n_closed;
            r_line_len <= n_line_len;
            r_remain   <= n_remain;
            r_skip     <= n_skip;
        end
    end

    hrdc_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push_q),
        .o_room  (w_room),
        .o_valid (o_m_tvalid),
        .o_head  (w_head),
        .i_pop   (i_m_tready)
    );

    assign o_m_tdata = {7'd0, w_head.chk, w_head.ver, w_head.status, w_head.body};
    assign o_m_tuser = w_head.kind;
    assign o_m_tlast = w_head.last;

endmodule

`default_nettype wire

### hdl/hrdc_res_fifo.sv
`default_nettype none

module hrdc_res_fifo
    import hrdc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_push   i_push,
    output logic         o_room,
    output logic         o_valid,
    output t_result      o_head,
    input  wire logic    i_pop
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr;
    logic [FIFO_AW-1:0]     r_rd;
    logic [FIFO_AW:0]       r_cnt;
    logic [FIFO_AW-1:0]     w_wr1;
    logic                   w_pop;

    assign w_pop   = i_pop && (r_cnt != '0);
    assign w_wr1   = r_wr + FIFO_AW'(1);
    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.e0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wr1] <= i_push.e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_AW'(i_push.cnt);
            r_rd  <= r_rd + FIFO_AW'(w_pop);
            r_cnt <= r_cnt + (FIFO_AW+1)'(i_push.cnt) - (FIFO_AW+1)'(w_pop);
        end
    end

endmodule

`default_nettype wire

### hdl/hrdc_checker.sv
`default_nettype none
`include "http_response_dechunker_defines.svh"

module hrdc_port_checker
    import hrdc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        i_s_tready,
    input wire logic        i_s_tlast,
    input wire logic        i_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] i_m_tdata,
    input wire logic [1:0]  i_m_tuser,
    input wire logic        i_m_tlast
);

    logic [34:0] w_m_word;
    logic        w_end_vld;
    logic        w_body_vld;
    logic        w_s_eos;

    assign w_m_word   = {i_m_tdata, i_m_tuser, i_m_tlast};
    assign w_end_vld  = i_m_tvalid && (i_m_tuser == KIND_END);
    assign w_body_vld = i_m_tvalid && (i_m_tuser == KIND_BODY);
    assign w_s_eos    = i_s_tvalid && i_s_tready && i_s_tlast;

    `HRDC_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, i_m_tvalid, i_m_tready, w_m_word)
    `HRDC_ASSERT(a_end_is_last, i_clk, i_rst_n, w_end_vld |-> i_m_tlast)
    `HRDC_ASSERT(a_body_clean, i_clk, i_rst_n, w_body_vld |-> (i_m_tdata[31:8] == 24'd0))
    `HRDC_ASSERT(a_eos_emits, i_clk, i_rst_n, w_s_eos |=> i_m_tvalid)

endmodule

bind http_response_dechunker hrdc_port_checker u_hrdc_port_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire

### dv/hrdc_checker.sv
`timescale 1ns / 100ps

module hrdc_checker
    import hrdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] stream_byte
    input  logic        i_s_tlast,   // end_of_stream
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [7:0] body_byte, [21:8] status_code,
                                     // [23:22] http_version, [24] is_chunked
    input  logic [1:0]  i_m_tuser,   // [1:0] result_kind
    input  logic        i_m_tlast,   // run_last
    output int          o_fail_count,
    output int          o_pending
);

    localparam int              HDR_WIN    = 26;
    localparam logic [63:0]     V11_TAG    = "HTTP/1.1";
    localparam logic [63:0]     V10_TAG    = "HTTP/1.0";
    localparam logic [207:0]    TE_CHUNKED = "Transfer-Encoding: chunked";
    localparam logic [31:0]     HDR_END    = 32'h0D0A_0D0A;
    localparam logic [15:0]     LINE_END   = 16'h0D0A;
    localparam logic [7:0]      CR         = 8'h0D;
    localparam logic [7:0]      LF         = 8'h0A;
    localparam longint unsigned SIZE_LIM   = (64'd1 << CHUNK_SIZE_BITS_DEF) - 64'd1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  body;
        logic [13:0] status;
        logic [1:0]  ver;
        logic        chunked;
        logic        last;
    } dec_word_t;

    logic [2:0]      phase;
    logic [207:0]    window;
    int              fill;
    int              status_acc;
    logic [1:0]      version;
    logic            chunked;
    longint unsigned size_acc;
    logic            digits_closed;
    int              line_len;
    longint unsigned remaining;
    int              skip_left;
    dec_word_t       decoded_words[$];
    int              fails = 0;

    function automatic void clear_state();
        phase         = PH_HEADER;
        window        = '0;
        fill          = 0;
        status_acc    = 0;
        version       = VER_NONE;
        chunked       = 1'b0;
        size_acc      = 0;
        digits_closed = 1'b0;
        line_len      = 0;
        remaining     = 0;
        skip_left     = 0;
    endfunction

    function automatic void shift_in(logic [7:0] b);
        window = {window[199:0], b};
        if (fill < HDR_WIN)
            fill++;
    endfunction

    function automatic bit tail_match(logic [207:0] pat, int n);
        logic [207:0] mask;
        mask = (208'd1 << (8 * n)) - 208'd1;
        return fill >= n && ((window ^ pat) & mask) == '0;
    endfunction

    function automatic int hex_nibble(logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b) - 48;
        if (b >= "a" && b <= "f")
            return int'(b) - 87;
        if (b >= "A" && b <= "F")
            return int'(b) - 55;
        return -1;
    endfunction

    function automatic void push_word(logic [1:0] k, logic [7:0] b, logic [13:0] st,
                                      logic [1:0] v, logic c);
        dec_word_t w;
        w.kind    = k;
        w.body    = b;
        w.status  = st;
        w.ver     = v;
        w.chunked = c;
        w.last    = 1'b0;
        decoded_words.push_back(w);
    endfunction

    function automatic void dechunk_byte(logic [7:0] b, logic eos);
        int  n0;
        int  h;
        bit  prev_cr;
        n0 = decoded_words.size();
        case (phase)
            PH_HEADER: begin
                shift_in(b);
                if (version == VER_NONE && tail_match(V11_TAG, 8)) begin
                    version    = VER_11;
                    status_acc = 0;
                    phase      = PH_STATUS;
                end else if (version == VER_NONE && tail_match(V10_TAG, 8)) begin
                    version    = VER_10;
                    status_acc = 0;
                    phase      = PH_STATUS;
                end else if (!chunked && tail_match(TE_CHUNKED, 26)) begin
                    chunked = 1'b1;
                end else if (tail_match(HDR_END, 4)) begin
                    push_word(KIND_SUMMARY, 8'd0, 14'(status_acc), version, chunked);
                    if (chunked) begin
                        phase         = PH_SIZE;
                        size_acc      = 0;
                        digits_closed = 1'b0;
                        line_len      = 0;
                    end else begin
                        phase = PH_PLAIN;
                    end
                end
            end
            PH_STATUS: begin
                shift_in(b);
                if (b >= "0" && b <= "9") begin
                    status_acc = status_acc * 10 + (int'(b) - 48);
                    if (status_acc > 9999)
                        status_acc = 9999;
                end else if (tail_match(LINE_END, 2)) begin
                    phase = PH_HEADER;
                end
            end
            PH_PLAIN: begin
                push_word(KIND_BODY, b, 14'd0, 2'd0, 1'b0);
            end
            PH_SIZE: begin
                prev_cr = line_len >= 1 && window[7:0] == CR;
                if (b == LF && prev_cr) begin
                    if (line_len >= 2) begin
                        remaining = size_acc;
                        if (remaining == 0) begin
                            skip_left = 2;
                            phase     = PH_SKIP;
                        end else begin
                            phase = PH_DATA;
                        end
                    end else begin
                        phase = PH_DONE;
                    end
                    size_acc      = 0;
                    digits_closed = 1'b0;
                    line_len      = 0;
                end else begin
                    h = hex_nibble(b);
                    if (!digits_closed) begin
                        if (h < 0)
                            digits_closed = 1'b1;
                        else if (size_acc > ((SIZE_LIM - longint'(h)) >> 4))
                            size_acc = SIZE_LIM;
                        else
                            size_acc = (size_acc << 4) + longint'(h);
                    end
                    shift_in(b);
                    if (line_len < 3)
                        line_len++;
                end
            end
            PH_DATA: begin
                push_word(KIND_BODY, b, 14'd0, 2'd0, 1'b0);
                if (remaining > 0)
                    remaining--;
                if (remaining == 0) begin
                    skip_left = 2;
                    phase     = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (skip_left > 0)
                    skip_left--;
                if (skip_left == 0)
                    phase = PH_SIZE;
            end
            default: begin
            end
        endcase
        if (eos) begin
            if (phase == PH_HEADER || phase == PH_STATUS)
                push_word(KIND_SUMMARY, 8'd0, 14'(status_acc), version, chunked);
            push_word(KIND_END, 8'd0, 14'd0, 2'd0, 1'b0);
            clear_state();
        end
        if (decoded_words.size() > n0)
            decoded_words[decoded_words.size() - 1].last = 1'b1;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            fails++;
        end
    endfunction

    function automatic void check_word();
        dec_word_t want;
        if (decoded_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, got tuser %0h tdata %h tlast %b",
                     $time, i_m_tuser, i_m_tdata, i_m_tlast);
            fails++;
            return;
        end
        want = decoded_words.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(i_m_tuser));
        check_field("body_byte", 32'(want.body), 32'(i_m_tdata[7:0]));
        check_field("status_code", 32'(want.status), 32'(i_m_tdata[21:8]));
        check_field("http_version", 32'(want.ver), 32'(i_m_tdata[23:22]));
        check_field("is_chunked", 32'(want.chunked), 32'(i_m_tdata[24]));
        check_field("tdata padding", 32'd0, 32'(i_m_tdata[31:25]));
        check_field("run_last", 32'(want.last), 32'(i_m_tlast));
    endfunction

    // compare outgoing words before predicting the incoming byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            decoded_words.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_word();
            if (i_s_tvalid && i_s_tready)
                dechunk_byte(i_s_tdata, i_s_tlast);
        end
        o_fail_count <= fails;
        o_pending    <= decoded_words.size();
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int         STALL_LIMIT = 2000;
    localparam int         BYTE_TARGET = 1100;
    localparam logic [7:0] CR          = 8'h0D;
    localparam logic [7:0] LF          = 8'h0A;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          pending;
    int          sent_bytes  = 0;
    int          idle_cycles = 0;
    int          stall_left  = 0;
    int          calm_left   = 0;
    logic        calm        = 1'b0;
    logic [7:0]  resp[$];

    http_response_dechunker DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    hrdc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // switch between stretches with and without idling
    always @(posedge clk) begin
        if (calm_left > 0) begin
            calm_left--;
        end else begin
            calm_left = $urandom_range(50, 300);
            calm <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_tready <= (stall_left == 0);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_response(input int cut);
        int n;
        int i;
        n = (cut > 0 && cut < resp.size()) ? cut : resp.size();
        for (i = 0; i < n; i++)
            send_word(resp[i], i == n - 1);
        resp.delete();
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            resp.push_back(s[i]);
    endtask

    task automatic add_crlf();
        resp.push_back(CR);
        resp.push_back(LF);
    endtask

    // framing bias favours line ends, hex digits and tag letters
    task automatic add_noise(input int n, input bit framing);
        repeat (n) begin
            if (framing && $urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0: resp.push_back(CR);
                    1: resp.push_back(LF);
                    2: resp.push_back("0");
                    3: resp.push_back("a");
                    4: resp.push_back("F");
                    default: resp.push_back("H");
                endcase
            end else begin
                resp.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic add_digits(input int n);
        repeat (n) resp.push_back(8'(32'h30 + $urandom_range(0, 9)));
    endtask

    task automatic add_size_line(input int v);
        logic [7:0] digs[$];
        int         d;
        do begin
            d = v % 16;
            if (d < 10)
                digs.push_front(8'(32'h30 + d));
            else if ($urandom_range(0, 1))
                digs.push_front(8'(32'h61 + d - 10));
            else
                digs.push_front(8'(32'h41 + d - 10));
            v = v / 16;
        end while (v > 0);
        if ($urandom_range(0, 3) == 0)
            digs.push_front("0");
        foreach (digs[i])
            resp.push_back(digs[i]);
        if ($urandom_range(0, 3) == 0)
            add_text(";ext=ab");
        add_crlf();
    endtask

    task automatic add_header(output bit te);
        int k;
        int j;
        int i;
        te = ($urandom_range(0, 1) != 0);
        if ($urandom_range(0, 7) != 0) begin
            if ($urandom_range(0, 1))
                add_text("HTTP/1.1 ");
            else
                add_text("HTTP/1.0 ");
            add_digits($urandom_range(1, 6));
            if ($urandom_range(0, 1))
                add_text(" OK");
            add_crlf();
        end
        k = $urandom_range(0, 3);
        j = $urandom_range(0, k);
        for (i = 0; i <= k; i++) begin
            if (te && i == j) begin
                add_text("Transfer-Encoding: chunked");
                add_crlf();
            end
            if (i < k) begin
                case ($urandom_range(0, 4))
                    0: add_text("Content-Type: text/html");
                    1: add_text("Via: HTTP/1.0 cache");
                    2: add_text("transfer-encoding: chunked");
                    3: add_text("Transfer-Encoding: gzip");
                    default: add_noise($urandom_range(1, 8), 0);
                endcase
                add_crlf();
            end
        end
        add_crlf();
    endtask

    task automatic add_chunked_body();
        int n;
        int len;
        int pick;
        n = $urandom_range(0, 4);
        repeat (n) begin
            len  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                add_noise($urandom_range(1, 4), 1);
                add_crlf();
            end else if (pick == 1) begin
                add_text("fFfFfFfFfF");
                add_crlf();
            end else begin
                add_size_line(len);
            end
            add_noise(len, 0);
            if ($urandom_range(0, 7) == 0)
                add_noise(2, 1);
            else
                add_crlf();
        end
        pick = $urandom_range(0, 5);
        if (pick == 1) begin
            add_text("0");
            add_crlf();
            add_crlf();
            add_crlf();
        end else if (pick != 0) begin
            add_crlf();
        end
        add_noise($urandom_range(0, 5), 1);
    endtask

    task automatic random_response();
        int r;
        int cut;
        bit te;
        r   = $urandom_range(0, 99);
        cut = 0;
        if (r < 15) begin
            add_noise($urandom_range(1, 30), 1);
        end else begin
            add_header(te);
            if (te)
                add_chunked_body();
            else
                add_noise($urandom_range(0, 24), 0);
            if (r < 35)
                cut = $urandom_range(1, resp.size());
        end
        send_response(cut);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        resp.push_back(8'h00);
        send_response(0);
        resp.push_back(8'hFF);
        send_response(0);

        add_text("HTTP/1.0 123456");
        add_crlf();
        add_crlf();
        add_text("AB");
        send_response(0);

        add_text("HTTP/1.1 200");
        add_crlf();
        add_text("Transfer-Encoding: chunked");
        add_crlf();
        add_crlf();
        add_text("a;1f");
        add_crlf();
        add_noise(10, 0);
        add_crlf();
        add_text("0");
        add_crlf();
        add_text("xy");
        add_crlf();
        add_text("zz");
        send_response(0);

        add_text("HTTP/1.1 204");
        add_crlf();
        add_text("Transfer-Encoding: chunked");
        add_crlf();
        add_crlf();
        add_text("fFfFfFfFfF");
        add_crlf();
        add_text("abc");
        send_response(0);

        while (sent_bytes < BYTE_TARGET)
            random_response();
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/hrdc_pkg.sv
hdl/hrdc_res_fifo.sv
hdl/http_response_dechunker.sv
hdl/hrdc_checker.sv
dv/hrdc_checker.sv
dv/tb_top.sv
